// ----- hw/rtl/salc_pkg.sv -----
// shared item types and codes for the set-associative lru cache
package salc_pkg;

  localparam int ADDR_FIELD_BITS = 16;
  localparam int DATA_FIELD_BITS = 32;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                               command;
    logic        [ADDR_FIELD_BITS-1:0]  address;
    logic signed [DATA_FIELD_BITS-1:0]  write_data;
  } req_item_t;

  typedef struct packed {
    logic                               hit;
    logic signed [DATA_FIELD_BITS-1:0]  read_data;
  } rsp_item_t;

endpackage

// ----- hw/rtl/set_assoc_lru_cache_unit.sv -----
// Set-associative cache with true lru replacement, one access per item.
// The cache holds SETS sets of WAYS ways; set = address mod SETS, tag = address / SETS.
// Sustained rate is one item per cycle while results are taken; an accepted item goes through
// address split, set row read, and lookup and update into the result register.
// The rate is set by the per-set row memory: one row read and one row write each cycle,
// with a bypass from the row just written to the row just read.
// After reset a clearing pass writes every row empty; req_ready stays low during it.
module set_assoc_lru_cache_unit #(
  parameter int SETS      = 4,
  parameter int WAYS      = 2,
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  salc_pkg::req_item_t  req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output salc_pkg::rsp_item_t  rsp
);

  import salc_pkg::*;

  localparam int LOG_SETS   = $clog2(SETS);
  localparam int FLOOR_LOG  = $clog2(SETS + 1) - 1;
  localparam int SET_BITS   = (SETS > 1) ? LOG_SETS : 1;
  localparam int TAG_RAW    = ADDR_BITS - FLOOR_LOG;
  localparam int TAG_BITS   = (TAG_RAW > 1) ? TAG_RAW : 1;
  localparam int RW         = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WIDX       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINE_W     = 1 + RW + TAG_BITS + DATA_BITS;
  localparam int ROW_W      = WAYS * LINE_W;
  localparam int PROD_W     = 2 * ADDR_BITS + 1;
  localparam int SHIFT      = ADDR_BITS + LOG_SETS;
  localparam int AW         = (ADDR_BITS > SET_BITS) ? ADDR_BITS : SET_BITS;
  localparam int AX         = (ADDR_BITS > ADDR_FIELD_BITS) ? ADDR_BITS : ADDR_FIELD_BITS;
  localparam int DX         = (DATA_BITS > DATA_FIELD_BITS) ? DATA_BITS : DATA_FIELD_BITS;

  localparam logic [63:0]        POW_SHIFT = 64'd1 << SHIFT;
  localparam logic [63:0]        MAGIC64   = (POW_SHIFT + 64'(SETS) - 64'd1) / 64'(SETS);
  localparam logic [ADDR_BITS:0] MAGIC     = MAGIC64[ADDR_BITS:0];
  localparam logic [RW-1:0]      RANK_LAST = RW'(WAYS - 1);
  localparam logic [SET_BITS-1:0] SET_LAST = SET_BITS'(SETS - 1);

  // clearing pass
  logic                clearing;
  logic [SET_BITS-1:0] clr_idx;

  // pipeline control
  logic v0, v1, v2;
  logic en_out, en2, en1, free0, free1, free2;

  // stage 0: accepted item
  logic                 cmd0;
  logic [ADDR_BITS-1:0] addr0;
  logic [DATA_BITS-1:0] wdata0;
  logic [AX-1:0]        addr_ext;
  logic [DX-1:0]        wdata_ext;
  logic [PROD_W-1:0]    product0;
  logic [PROD_W-1:0]    quot_full0;

  // stage 1: tag known, set row read
  logic                 cmd1;
  logic [ADDR_BITS-1:0] addr1;
  logic [TAG_BITS-1:0]  tag1;
  logic [DATA_BITS-1:0] wdata1;
  logic [AW-1:0]        rem1;
  logic [SET_BITS-1:0]  set1;

  // stage 2: lookup and update
  logic                 cmd2;
  logic [TAG_BITS-1:0]  tag2;
  logic [SET_BITS-1:0]  set2;
  logic [DATA_BITS-1:0] wdata2;
  logic                 byp_hit;
  logic [ROW_W-1:0]     byp_row;
  logic [ROW_W-1:0]     ram_row;
  logic [ROW_W-1:0]     row2;
  logic [ROW_W-1:0]     new_row;

  logic [WAYS-1:0]      cur_valid;
  logic [RW-1:0]        cur_rank [WAYS];
  logic [TAG_BITS-1:0]  cur_tag  [WAYS];
  logic [DATA_BITS-1:0] cur_data [WAYS];
  logic [WAYS-1:0]      new_valid;
  logic [RW-1:0]        new_rank [WAYS];
  logic [TAG_BITS-1:0]  new_tag  [WAYS];
  logic [DATA_BITS-1:0] new_data [WAYS];

  logic [WAYS-1:0]      hit_vec;
  logic                 found;
  logic [WIDX-1:0]      found_idx;
  logic                 any_free;
  logic [WIDX-1:0]      free_idx;
  logic                 lru_found;
  logic [WIDX-1:0]      lru_idx;
  logic [WIDX-1:0]      tgt;
  logic                 do_touch;
  logic                 inc_all;
  logic [RW-1:0]        tgt_rank;
  logic [DX-1:0]        rdata_ext;
  logic [DATA_FIELD_BITS-1:0] read_data2;

  // ram ports
  logic                 ram_we;
  logic [SET_BITS-1:0]  ram_waddr;
  logic [ROW_W-1:0]     ram_wdata;

  // handshake and stage movement
  assign en_out    = v2 && (!rsp_valid || rsp_ready);
  assign free2     = !v2 || en_out;
  assign en2       = v1 && free2;
  assign free1     = !v1 || en2;
  assign en1       = v0 && free1;
  assign free0     = !v0 || en1;
  assign req_ready = free0 && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      rsp_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_idx   <= '0;
    end else begin
      if (req_valid && req_ready) begin
        v0 <= 1'b1;
      end else if (en1) begin
        v0 <= 1'b0;
      end
      if (en1) begin
        v1 <= 1'b1;
      end else if (en2) begin
        v1 <= 1'b0;
      end
      if (en2) begin
        v2 <= 1'b1;
      end else if (en_out) begin
        v2 <= 1'b0;
      end
      if (en_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (clearing) begin
        if (clr_idx == SET_LAST) begin
          clearing <= 1'b0;
        end
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // stage 0
  assign addr_ext  = AX'(req.address);
  assign wdata_ext = DX'($unsigned(req.write_data));

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd0   <= req.command;
      addr0  <= addr_ext[ADDR_BITS-1:0];
      wdata0 <= wdata_ext[DATA_BITS-1:0];
    end
  end

  // tag = address / SETS by reciprocal multiply
  assign product0   = PROD_W'(addr0) * PROD_W'(MAGIC);
  assign quot_full0 = product0 >> SHIFT;

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1   <= cmd0;
      addr1  <= addr0;
      tag1   <= quot_full0[TAG_BITS-1:0];
      wdata1 <= wdata0;
    end
  end

  // stage 1: set = address - tag * SETS
  assign rem1 = AW'(addr1) - AW'(tag1) * AW'(SETS);
  assign set1 = rem1[SET_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en2) begin
      cmd2    <= cmd1;
      tag2    <= tag1;
      set2    <= set1;
      wdata2  <= wdata1;
      byp_hit <= en_out && (set2 == set1);
    end
    if (en_out) begin
      byp_row <= new_row;
    end
  end

  assign ram_we    = clearing || en_out;
  assign ram_waddr = clearing ? clr_idx : set2;
  assign ram_wdata = clearing ? '0 : new_row;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en2),
    .raddr (set1),
    .rdata (ram_row)
  );

  // stage 2: lookup
  assign row2 = byp_hit ? byp_row : ram_row;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      cur_valid[i] = row2[i*LINE_W + LINE_W - 1];
      cur_rank[i]  = row2[i*LINE_W + DATA_BITS + TAG_BITS +: RW];
      cur_tag[i]   = row2[i*LINE_W + DATA_BITS +: TAG_BITS];
      cur_data[i]  = row2[i*LINE_W +: DATA_BITS];
      hit_vec[i]   = cur_valid[i] && (cur_tag[i] == tag2);
    end
  end

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    any_free  = 1'b0;
    free_idx  = '0;
    lru_found = 1'b0;
    lru_idx   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (hit_vec[i] && !found) begin
        found     = 1'b1;
        found_idx = WIDX'(i);
      end
      if (!cur_valid[i] && !any_free) begin
        any_free = 1'b1;
        free_idx = WIDX'(i);
      end
      if (cur_valid[i] && (cur_rank[i] == RANK_LAST) && !lru_found) begin
        lru_found = 1'b1;
        lru_idx   = WIDX'(i);
      end
    end
  end

  // stage 2: update of the set row
  always_comb begin
    priority if (found) begin
      tgt = found_idx;
    end else if (any_free) begin
      tgt = free_idx;
    end else begin
      tgt = lru_idx;
    end
    do_touch = found || (cmd2 == CMD_WRITE);
    inc_all  = (cmd2 == CMD_WRITE) && !found && any_free;
    tgt_rank = cur_rank[tgt];
    for (int i = 0; i < WAYS; i++) begin
      new_valid[i] = cur_valid[i];
      new_rank[i]  = cur_rank[i];
      new_tag[i]   = cur_tag[i];
      new_data[i]  = cur_data[i];
      if (do_touch) begin
        if (WIDX'(i) == tgt) begin
          new_rank[i] = '0;
        end else if (cur_valid[i] && (inc_all || (cur_rank[i] < tgt_rank))) begin
          new_rank[i] = cur_rank[i] + 1'b1;
        end
      end
      if ((cmd2 == CMD_WRITE) && (WIDX'(i) == tgt)) begin
        new_valid[i] = 1'b1;
        new_data[i]  = wdata2;
        if (!found) begin
          new_tag[i] = tag2;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      new_row[i*LINE_W +: LINE_W] = {new_valid[i], new_rank[i], new_tag[i], new_data[i]};
    end
  end

  assign rdata_ext  = DX'(cur_data[found_idx]);
  assign read_data2 = ((cmd2 == CMD_READ) && found) ? rdata_ext[DATA_FIELD_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (en_out) begin
      rsp.hit       <= found;
      rsp.read_data <= signed'(read_data2);
    end
  end

  // no item may be in flight while the rows are being cleared
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!v0 && !v1 && !v2 && !rsp_valid))
    else $error("item in flight during clearing pass");

  // a tag is present at most once in a set
  a_tag_unique: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $onehot0(hit_vec))
    else $error("duplicate tag in set");

  // reads never change which lines are valid
  a_read_keeps_valid: assert property (@(posedge clk) disable iff (rst)
    (v2 && (cmd2 == CMD_READ)) |-> (new_valid == cur_valid))
    else $error("read changed valid bits");

  // a write miss into a set with a free way adds exactly one line
  a_fill_adds_one: assert property (@(posedge clk) disable iff (rst)
    (v2 && inc_all) |-> ($countones(new_valid) == $countones(cur_valid) + 1))
    else $error("fill did not add one line");

endmodule

// ----- hw/rtl/salc_ram.sv -----
// generic simple dual-port ram with registered read
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/set_assoc_lru_cache_checker.sv -----
// checker for the set-associative lru cache: predicts each access result and compares
module set_assoc_lru_cache_checker #(
  parameter int SETS = 4,
  parameter int WAYS = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  salc_pkg::req_item_t req,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  salc_pkg::rsp_item_t rsp,
  output int                  fail_count,
  output int                  pending
);
  import salc_pkg::*;

  localparam int LINES = SETS * WAYS;
  localparam int REPORT_LIMIT = 10;

  logic                       way_valid [LINES];
  logic [ADDR_FIELD_BITS-1:0] way_tag   [LINES];
  logic [DATA_FIELD_BITS-1:0] way_word  [LINES];
  int                         way_age   [LINES];
  rsp_item_t                  expected_rsp [$];

  function automatic void clear_cache();
    int i;
    for (i = 0; i < LINES; i++) begin
      way_valid[i] = 1'b0;
      way_tag[i]   = '0;
      way_word[i]  = '0;
      way_age[i]   = 0;
    end
  endfunction

  function automatic void make_newest(int base, int way);
    int old_age;
    int w;
    old_age = way_age[base + way];
    for (w = 0; w < WAYS; w++) begin
      if (way_valid[base + w] && way_age[base + w] < old_age) way_age[base + w]++;
    end
    way_age[base + way] = 0;
  endfunction

  function automatic rsp_item_t access_cache(req_item_t item);
    int                         base;
    int                         hit_way;
    int                         fill_way;
    int                         w;
    logic [ADDR_FIELD_BITS-1:0] tag;
    rsp_item_t                  result;
    base    = int'(item.address % SETS) * WAYS;
    tag     = ADDR_FIELD_BITS'(item.address / SETS);
    hit_way = -1;
    for (w = 0; w < WAYS; w++) begin
      if (hit_way < 0 && way_valid[base + w] && way_tag[base + w] == tag) hit_way = w;
    end
    result.hit       = (hit_way >= 0);
    result.read_data = '0;
    if (item.command == CMD_READ) begin
      if (hit_way >= 0) begin
        result.read_data = way_word[base + hit_way];
        make_newest(base, hit_way);
      end
    end else if (hit_way >= 0) begin
      way_word[base + hit_way] = item.write_data;
      make_newest(base, hit_way);
    end else begin
      fill_way = -1;
      for (w = 0; w < WAYS; w++) begin
        if (fill_way < 0 && !way_valid[base + w]) fill_way = w;
      end
      if (fill_way >= 0) begin
        for (w = 0; w < WAYS; w++) begin
          if (way_valid[base + w]) way_age[base + w]++;
        end
        way_valid[base + fill_way] = 1'b1;
        way_age[base + fill_way]   = 0;
      end else begin
        // full set: replace the least recently used way
        fill_way = 0;
        for (w = 0; w < WAYS; w++) begin
          if (way_age[base + w] >= way_age[base + fill_way]) fill_way = w;
        end
        make_newest(base, fill_way);
      end
      way_tag[base + fill_way]  = tag;
      way_word[base + fill_way] = item.write_data;
    end
    return result;
  endfunction

  function automatic void note_mismatch(string field, logic [DATA_FIELD_BITS-1:0] want,
                                        logic [DATA_FIELD_BITS-1:0] got);
    if (fail_count < REPORT_LIMIT) begin
      $display("mismatch in %s: expected %h, got %h", field, want, got);
    end
    fail_count++;
  endfunction

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      clear_cache();
      expected_rsp.delete();
      fail_count = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("unexpected result: hit %b read_data %h", rsp.hit, rsp.read_data);
          end
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.hit !== want.hit) note_mismatch("hit", 32'(want.hit), 32'(rsp.hit));
          if (rsp.read_data !== want.read_data) begin
            note_mismatch("read_data", want.read_data, rsp.read_data);
          end
        end
      end
      if (req_valid && req_ready) expected_rsp.push_back(access_cache(req));
    end
    pending <= expected_rsp.size();
  end

endmodule

// ----- tb/tb_set_assoc_lru_cache_unit.sv -----
// testbench top: drives cache accesses under idle and stall phases and gives the verdict
module tb_set_assoc_lru_cache_unit;
  import salc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 283;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  int fail_count;
  int pending;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  set_assoc_lru_cache_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  set_assoc_lru_cache_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_access(input logic cmd, input logic [ADDR_FIELD_BITS-1:0] addr,
                             input logic [DATA_FIELD_BITS-1:0] wdata);
    req_item_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      item.command    = 1'($urandom);
      item.address    = 16'($urandom);
      item.write_data = $urandom;
      req_valid <= 1'b0;
      req       <= item;
      @(posedge clk);
    end
    item.command    = cmd;
    item.address    = addr;
    item.write_data = wdata;
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  function automatic logic [ADDR_FIELD_BITS-1:0] pick_address();
    int mode;
    mode = $urandom_range(0, 9);
    // narrow pools keep three tags per set in play so hits and evictions are common
    if (mode < 4) return 16'($urandom_range(0, 11));
    if (mode < 7) return 16'hFFFF - 16'($urandom_range(0, 11));
    return 16'($urandom);
  endfunction

  function automatic logic [DATA_FIELD_BITS-1:0] pick_data();
    case ($urandom_range(0, 19))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, pick_address(), pick_data());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty read, fills, lru eviction, write hit, address extremes
    send_access(CMD_READ,  16'h0000, 32'hFFFF_FFFF);
    send_access(CMD_WRITE, 16'h0000, 32'h8000_0000);
    send_access(CMD_READ,  16'h0000, 32'h1234_5678);
    send_access(CMD_WRITE, 16'h0004, 32'h7FFF_FFFF);
    send_access(CMD_READ,  16'h0000, 32'h0000_0000);
    send_access(CMD_WRITE, 16'h0008, 32'hA5A5_A5A5);
    send_access(CMD_READ,  16'h0004, 32'h0000_0000);
    send_access(CMD_READ,  16'h0000, 32'h0000_0000);
    send_access(CMD_WRITE, 16'h0000, 32'hFFFF_FFFF);
    send_access(CMD_READ,  16'h0008, 32'h0000_0000);
    send_access(CMD_READ,  16'h0000, 32'h0000_0000);
    send_access(CMD_WRITE, 16'hFFFF, 32'h0000_0000);
    send_access(CMD_READ,  16'hFFFF, 32'hFFFF_FFFF);
    send_access(CMD_WRITE, 16'hFFFB, 32'h5555_5555);
    send_access(CMD_WRITE, 16'hFFF7, 32'hAAAA_AAAA);
    send_access(CMD_READ,  16'hFFFF, 32'h0000_0000);
    send_access(CMD_READ,  16'hFFFB, 32'h0000_0000);
    send_access(CMD_READ,  16'hFFF7, 32'h0000_0000);
    send_access(CMD_WRITE, 16'h0001, 32'h0000_0001);
    send_access(CMD_WRITE, 16'h0002, 32'h0000_0002);
    send_access(CMD_READ,  16'h0001, 32'h0000_0000);
    send_access(CMD_READ,  16'h0002, 32'h0000_0000);

    run_random(PHASE_ITEMS);
    send_idle_pct  = 57;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    run_random(PHASE_ITEMS);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    run_random(PHASE_ITEMS);

    req_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/salc_pkg.sv
hw/rtl/salc_ram.sv
hw/rtl/set_assoc_lru_cache_unit.sv
tb/set_assoc_lru_cache_checker.sv
tb/tb_set_assoc_lru_cache_unit.sv
